// ===== hw/rtl/hsfd_pkg.sv =====
package hsfd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned SCALE_W = 15;
  localparam int unsigned PROD_W  = WORD_W + SCALE_W;
  localparam int unsigned QUOT_W  = PROD_W - WORD_W;
  localparam int unsigned TEMP_W  = 15;
  localparam int unsigned HUM_W   = 14;

  localparam logic [BYTE_W-1:0]  CRC_INIT    = 8'hFF;
  localparam logic [BYTE_W-1:0]  CRC_POLY    = 8'h31;
  localparam logic [SCALE_W-1:0] TEMP_SCALE  = 15'd17500;
  localparam logic [SCALE_W-1:0] HUM_SCALE   = 15'd10000;
  localparam logic [TEMP_W-1:0]  TEMP_OFFSET = 15'd4500;

  function automatic logic [BYTE_W-1:0] crc_feed(input logic [BYTE_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = crc ^ b;
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/humidity_sensor_frame_decode_unit.sv =====
// Channel   Dir  Transaction  Payload
// s_axis    in   one byte     tdata: data_byte; tuser: frame_start
// m_axis    out  one result   tdata: temperature_centi, humidity_centi; tuser: fresh flags
//
// One byte per cycle, but a sixth byte waits while the result register is stalled; a
// byte passes the input register, then CRC, scaling and divide into the result register.
// The sixth byte of a frame yields one result; other bytes yield none.
// rst clears the byte count, CRC, held values and both valid flags.
// A byte that yields no result proceeds while the result register is stalled.
module humidity_sensor_frame_decode_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [14:0] temperature_centi, [28:15] humidity_centi
  output logic [1:0]  m_axis_tuser    // [0] temperature_fresh, [1] humidity_fresh
);

  localparam logic [2:0] POS_T_HI  = 3'd0;
  localparam logic [2:0] POS_T_LO  = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_HI  = 3'd3;
  localparam logic [2:0] POS_H_LO  = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  logic                          in_valid;
  logic [hsfd_pkg::BYTE_W-1:0]   in_byte;
  logic                          in_start;

  logic [2:0]                    byte_position, byte_position_next;
  logic [hsfd_pkg::BYTE_W-1:0]   running_crc, running_crc_next;
  logic [hsfd_pkg::BYTE_W-1:0]   word_high_byte, word_high_byte_next;
  logic [hsfd_pkg::PROD_W-1:0]   product, product_next;
  logic                          pending_temperature_ok, pending_temperature_ok_next;
  logic [hsfd_pkg::TEMP_W-1:0]   held_temperature, held_temperature_next;
  logic [hsfd_pkg::HUM_W-1:0]    held_humidity, held_humidity_next;

  logic                          out_valid;
  logic [hsfd_pkg::TEMP_W-1:0]   out_temp;
  logic [hsfd_pkg::HUM_W-1:0]    out_hum;
  logic                          out_temp_fresh;
  logic                          out_hum_fresh;

  logic [2:0]                    pos;
  logic                          emits;
  logic                          out_free;
  logic                          proc;
  logic                          crc_ok;
  logic [hsfd_pkg::BYTE_W-1:0]   crc_step;
  logic [hsfd_pkg::SCALE_W-1:0]  scale_sel;
  logic [hsfd_pkg::PROD_W-1:0]   prod_calc;
  logic [hsfd_pkg::QUOT_W-1:0]   quot;

  always_comb begin
    if (in_start || byte_position > POS_H_CRC) begin
      pos = POS_T_HI;
    end else begin
      pos = byte_position;
    end
  end

  assign emits         = pos == POS_H_CRC;
  assign out_free      = !out_valid || m_axis_tready;
  assign proc          = in_valid && (!emits || out_free);
  assign s_axis_tready = !in_valid || proc;

  assign crc_ok    = in_byte == running_crc;
  assign crc_step  = hsfd_pkg::crc_feed((pos == POS_T_HI || pos == POS_H_HI)
                                        ? hsfd_pkg::CRC_INIT : running_crc, in_byte);
  assign scale_sel = (pos == POS_T_LO) ? hsfd_pkg::TEMP_SCALE : hsfd_pkg::HUM_SCALE;
  assign prod_calc = {{hsfd_pkg::WORD_W{1'b0}}, scale_sel}
                   * {{hsfd_pkg::SCALE_W{1'b0}}, word_high_byte, in_byte};

  hsfd_div65535 u_div (
    .prod (product),
    .quot (quot)
  );

  always_comb begin
    byte_position_next          = byte_position;
    running_crc_next            = running_crc;
    word_high_byte_next         = word_high_byte;
    product_next                = product;
    pending_temperature_ok_next = pending_temperature_ok;
    held_temperature_next       = held_temperature;
    held_humidity_next          = held_humidity;
    unique case (pos)
      POS_T_HI, POS_H_HI: begin
        running_crc_next    = crc_step;
        word_high_byte_next = in_byte;
        byte_position_next  = pos + 3'd1;
      end
      POS_T_LO, POS_H_LO: begin
        running_crc_next   = crc_step;
        product_next       = prod_calc;
        byte_position_next = pos + 3'd1;
      end
      POS_T_CRC: begin
        pending_temperature_ok_next = crc_ok;
        if (crc_ok) begin
          held_temperature_next = quot - hsfd_pkg::TEMP_OFFSET;
        end
        running_crc_next   = hsfd_pkg::CRC_INIT;
        byte_position_next = POS_H_HI;
      end
      POS_H_CRC: begin
        if (crc_ok) begin
          held_humidity_next = quot[hsfd_pkg::HUM_W-1:0];
        end
        running_crc_next   = hsfd_pkg::CRC_INIT;
        byte_position_next = POS_T_HI;
      end
      default: begin
        byte_position_next = POS_T_HI;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte  <= s_axis_tdata;
      in_start <= s_axis_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position          <= POS_T_HI;
      running_crc            <= hsfd_pkg::CRC_INIT;
      word_high_byte         <= '0;
      product                <= '0;
      pending_temperature_ok <= 1'b0;
      held_temperature       <= '0;
      held_humidity          <= '0;
    end else if (proc) begin
      byte_position          <= byte_position_next;
      running_crc            <= running_crc_next;
      word_high_byte         <= word_high_byte_next;
      product                <= product_next;
      pending_temperature_ok <= pending_temperature_ok_next;
      held_temperature       <= held_temperature_next;
      held_humidity          <= held_humidity_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc && emits) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && emits) begin
      out_temp       <= held_temperature;
      out_hum        <= held_humidity_next;
      out_temp_fresh <= pending_temperature_ok;
      out_hum_fresh  <= crc_ok;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'd0, out_hum, out_temp};
  assign m_axis_tuser  = {out_hum_fresh, out_temp_fresh};

endmodule

// ===== hw/rtl/hsfd_div65535.sv =====
module hsfd_div65535 (
  input  logic [hsfd_pkg::PROD_W-1:0] prod,
  output logic [hsfd_pkg::QUOT_W-1:0] quot
);

  logic [hsfd_pkg::QUOT_W-1:0] q0;
  logic [hsfd_pkg::WORD_W:0]   rem;
  logic                        carry;

  // p / (2^16 - 1): high half plus one correction when remainder reaches the divisor
  assign q0    = prod[hsfd_pkg::PROD_W-1:hsfd_pkg::WORD_W];
  assign rem   = {1'b0, prod[hsfd_pkg::WORD_W-1:0]}
               + {{(hsfd_pkg::WORD_W+1-hsfd_pkg::QUOT_W){1'b0}}, q0};
  assign carry = rem >= {1'b0, {hsfd_pkg::WORD_W{1'b1}}};
  assign quot  = q0 + {{(hsfd_pkg::QUOT_W-1){1'b0}}, carry};

endmodule
